/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared defaults, operation and status codes, and the cell control struct.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int VALUE_WIDTH_DEF  = 16;
  localparam int WEIGHT_WIDTH_DEF = 16;

  // operation codes carried in the mode field
  localparam logic MODE_JOIN  = 1'b0;
  localparam logic MODE_LEAVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast control from the queue controller to every cell
  typedef struct packed {
    logic join_op;
    logic leave_op;
  } cell_ctrl_t;

endpackage

/* hw/rtl/spq_if.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if #(
  parameter int VALUE_WIDTH  = spq_pkg::VALUE_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = spq_pkg::WEIGHT_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic        [VALUE_WIDTH-1:0]  item_value;
  logic signed [WEIGHT_WIDTH-1:0] priority_req;

  modport source (output valid, mode, item_value, priority_req, input ready);
  modport sink   (input valid, mode, item_value, priority_req, output ready);
endinterface

interface spq_rsp_if #(
  parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = $clog2(spq_pkg::CAPACITY_DEF + 1)
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [1:0]             status;
  logic                   is_empty;
  logic [COUNT_WIDTH-1:0] fill_count;

  modport source (output valid, out_value, status, is_empty, fill_count, input ready);
  modport sink   (input valid, out_value, status, is_empty, fill_count, output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on a join it keeps, takes the new entry or takes its left
// neighbor; on a leave it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int VALUE_WIDTH  = spq_pkg::VALUE_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = spq_pkg::WEIGHT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spq_pkg::cell_ctrl_t            ctrl,
  input  logic        [VALUE_WIDTH-1:0]  new_value,
  input  logic signed [WEIGHT_WIDTH-1:0] new_weight,
  input  logic                           left_ins,
  input  logic                           left_valid,
  input  logic        [VALUE_WIDTH-1:0]  left_value,
  input  logic signed [WEIGHT_WIDTH-1:0] left_weight,
  input  logic                           right_valid,
  input  logic        [VALUE_WIDTH-1:0]  right_value,
  input  logic signed [WEIGHT_WIDTH-1:0] right_weight,
  output logic                           ins,
  output logic                           valid,
  output logic        [VALUE_WIDTH-1:0]  value,
  output logic signed [WEIGHT_WIDTH-1:0] weight
);

  // new entry belongs at or before this slot
  assign ins = !valid || (new_weight > weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.join_op) begin
      if (left_ins) begin
        valid <= left_valid;
      end else if (ins) begin
        valid <= 1'b1;
      end
    end else if (ctrl.leave_op) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.join_op) begin
      if (left_ins) begin
        value  <= left_value;
        weight <= left_weight;
      end else if (ins) begin
        value  <= new_value;
        weight <= new_weight;
      end
    end else if (ctrl.leave_op) begin
      value  <= right_value;
      weight <= right_weight;
    end
  end

endmodule

/* hw/rtl/sorted_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Max-first priority queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY entries, each a value with a signed weight,
// kept in a row of cells sorted largest weight first; equal weights leave in
// arrival order. A join request broadcasts the new entry to every cell, each
// cell compares it with its own weight, and the cells behind the insertion
// point shift one place right while the insertion cell captures the new
// entry. A leave shifts every cell one place left and returns the front
// value. Every request passes through the cell row and produces exactly one
// response, loaded into the response register in the next cycle; a new
// request is taken every cycle as long as the response register is empty or
// is being drained in the same cycle, so the sustained rate is one transfer
// per clock. A leave on an empty queue returns the empty status, a join on a
// full queue is dropped with the full status; both leave the queue unchanged.
// There is no clearing pass: reset empties the queue at once.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int CAPACITY     = spq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH  = spq_pkg::VALUE_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = spq_pkg::WEIGHT_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst,
  spq_req_if.sink req,
  spq_rsp_if.source rsp
);

  localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

  // row of cells
  logic        [CAPACITY-1:0]     c_valid;
  logic        [CAPACITY-1:0]     c_ins;
  logic        [VALUE_WIDTH-1:0]  c_value  [CAPACITY];
  logic signed [WEIGHT_WIDTH-1:0] c_weight [CAPACITY];

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;

  logic                 req_xfer;
  logic                 rsp_xfer;
  logic                 is_full;
  logic                 is_none;
  spq_pkg::cell_ctrl_t  ctrl;

  // take a request whenever the response register frees up this cycle
  assign req.ready = !rsp.valid || rsp.ready;
  assign req_xfer  = req.valid && req.ready;
  assign rsp_xfer  = rsp.valid && rsp.ready;

  assign is_full = (count == COUNT_WIDTH'(CAPACITY));
  assign is_none = (count == '0);

  // drop operations that would overflow or underflow
  assign ctrl.join_op  = req_xfer && (req.mode == spq_pkg::MODE_JOIN) && !is_full;
  assign ctrl.leave_op = req_xfer && (req.mode == spq_pkg::MODE_LEAVE) && !is_none;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                           l_ins;
      logic                           l_valid;
      logic        [VALUE_WIDTH-1:0]  l_value;
      logic signed [WEIGHT_WIDTH-1:0] l_weight;
      logic                           r_valid;
      logic        [VALUE_WIDTH-1:0]  r_value;
      logic signed [WEIGHT_WIDTH-1:0] r_weight;

      // front cell has no left neighbor: nothing shifts into it on a join
      if (gi == 0) begin : g_front
        assign l_ins    = 1'b0;
        assign l_valid  = 1'b0;
        assign l_value  = '0;
        assign l_weight = '0;
      end else begin : g_mid_l
        assign l_ins    = c_ins[gi-1];
        assign l_valid  = c_valid[gi-1];
        assign l_value  = c_value[gi-1];
        assign l_weight = c_weight[gi-1];
      end

      // back cell empties on a leave
      if (gi == CAPACITY - 1) begin : g_back
        assign r_valid  = 1'b0;
        assign r_value  = '0;
        assign r_weight = '0;
      end else begin : g_mid_r
        assign r_valid  = c_valid[gi+1];
        assign r_value  = c_value[gi+1];
        assign r_weight = c_weight[gi+1];
      end

      spq_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .WEIGHT_WIDTH(WEIGHT_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .new_value   (req.item_value),
        .new_weight  (req.priority_req),
        .left_ins    (l_ins),
        .left_valid  (l_valid),
        .left_value  (l_value),
        .left_weight (l_weight),
        .right_valid (r_valid),
        .right_value (r_value),
        .right_weight(r_weight),
        .ins         (c_ins[gi]),
        .valid       (c_valid[gi]),
        .value       (c_value[gi]),
        .weight      (c_weight[gi])
      );
    end
  endgenerate

  // occupancy after this request
  always_comb begin
    count_next = count;
    if (ctrl.join_op) begin
      count_next = count + COUNT_WIDTH'(1);
    end else if (ctrl.leave_op) begin
      count_next = count - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response register: hold until transferred, load on every request
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req_xfer) begin
      rsp.valid <= 1'b1;
    end else if (rsp_xfer) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      rsp.out_value  <= ctrl.leave_op ? c_value[0] : '0;
      rsp.is_empty   <= (count_next == '0);
      rsp.fill_count <= count_next;
      priority if (req.mode == spq_pkg::MODE_JOIN && is_full) begin
        rsp.status <= spq_pkg::ST_FULL;
      end else if (req.mode == spq_pkg::MODE_LEAVE && is_none) begin
        rsp.status <= spq_pkg::ST_EMPTY;
      end else begin
        rsp.status <= spq_pkg::ST_OK;
      end
    end
  end

  // occupied cells form a solid block at the front of the row
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    count == COUNT_WIDTH'($countones(c_valid)))
    else $error("occupancy disagrees with valid cells");

  a_front_valid: assert property (@(posedge clk) disable iff (rst)
    c_valid[0] == (count != '0))
    else $error("front cell valid disagrees with occupancy");

  a_full_join_holds: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.mode == spq_pkg::MODE_JOIN && is_full) |=>
      (count == $past(count) && rsp.status == spq_pkg::ST_FULL))
    else $error("dropped join changed the queue");

  a_leave_ok: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.mode == spq_pkg::MODE_LEAVE && !is_none) |=>
      (rsp.valid && rsp.status == spq_pkg::ST_OK && rsp.out_value == $past(c_value[0])))
    else $error("leave did not return the front entry");

endmodule

/* tb/tb_sorted_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives join and leave requests through the request channel, predicts every
// response with a sorted-list model of the queue, and checks each response
// field by field under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;

  localparam int CAP         = spq_pkg::CAPACITY_DEF;
  localparam int VW          = spq_pkg::VALUE_WIDTH_DEF;
  localparam int WW          = spq_pkg::WEIGHT_WIDTH_DEF;
  localparam int CW          = $clog2(spq_pkg::CAPACITY_DEF + 1);
  localparam int RAND_ITEMS  = 160;   // random items per idling phase
  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [VW-1:0] out_value;
    logic [1:0]    status;
    logic          is_empty;
    logic [CW-1:0] fill_count;
  } pq_result_t;

  // Shadow of the queue contents plus the responses still owed by the block.
  class queue_scoreboard;
    logic        [VW-1:0] slot_value  [CAP];
    logic signed [WW-1:0] slot_weight [CAP];
    int                   held;
    pq_result_t           owed_q [$];
    int                   fails;

    function new();
      held  = 0;
      fails = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report_mismatch(string msg);
      if (fails < PRINT_LIMIT) $display("mismatch: %s", msg);
      fails++;
    endtask

    // Apply one accepted request to the shadow queue and record its response.
    function void note_request(logic op, logic [VW-1:0] value,
                               logic signed [WW-1:0] weight);
      pq_result_t r;
      int         pos;
      r = '0;
      r.status = spq_pkg::ST_OK;
      if (op == spq_pkg::MODE_JOIN) begin
        if (held >= CAP) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          // skip every entry that is at least as heavy: ties keep arrival order
          pos = 0;
          while (pos < held && !(weight > slot_weight[pos])) pos++;
          for (int i = held; i > pos; i--) begin
            slot_value[i]  = slot_value[i-1];
            slot_weight[i] = slot_weight[i-1];
          end
          slot_value[pos]  = value;
          slot_weight[pos] = weight;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.out_value = slot_value[0];
          for (int i = 1; i < held; i++) begin
            slot_value[i-1]  = slot_value[i];
            slot_weight[i-1] = slot_weight[i];
          end
          held--;
        end
      end
      r.is_empty   = (held == 0);
      r.fill_count = held[CW-1:0];
      owed_q.push_back(r);
    endfunction

    task check_response(pq_result_t got);
      pq_result_t exp_r;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("response with nothing owed: %p", got));
        return;
      end
      exp_r = owed_q.pop_front();
      if (got.out_value !== exp_r.out_value)
        report_mismatch($sformatf("out_value %h, expected %h",
                                  got.out_value, exp_r.out_value));
      if (got.status !== exp_r.status)
        report_mismatch($sformatf("status %0d, expected %0d",
                                  got.status, exp_r.status));
      if (got.is_empty !== exp_r.is_empty)
        report_mismatch($sformatf("is_empty %b, expected %b",
                                  got.is_empty, exp_r.is_empty));
      if (got.fill_count !== exp_r.fill_count)
        report_mismatch($sformatf("fill_count %0d, expected %0d",
                                  got.fill_count, exp_r.fill_count));
    endtask
  endclass

  logic clk;
  logic rst;

  spq_req_if #(.VALUE_WIDTH(VW), .WEIGHT_WIDTH(WW)) req_ch ();
  spq_rsp_if #(.VALUE_WIDTH(VW), .COUNT_WIDTH(CW))  rsp_ch ();

  sorted_priority_queue_core #(
    .CAPACITY     (CAP),
    .VALUE_WIDTH  (VW),
    .WEIGHT_WIDTH (WW)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  queue_scoreboard sb = new();

  int send_idle_pct = 0;   // chance per item slot that the sender holds off
  int rsp_stall_pct = 0;   // chance per cycle that the receiver stalls
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stall at random, one decision per clock.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Monitor both channels at each edge. Check the response first: it can only
  // belong to a request that was noted at an earlier edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response('{rsp_ch.out_value, rsp_ch.status,
                            rsp_ch.is_empty, rsp_ch.fill_count});
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.mode, req_ch.item_value, req_ch.priority_req);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: end the run when nothing has moved for too long.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Present one request, idling first at the phase's rate, and hold it until
  // the transfer happens. Keep valid high across back-to-back requests.
  task automatic send_request(input logic op, input logic [VW-1:0] value,
                              input logic signed [WW-1:0] weight);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= op;
    req_ch.item_value   <= value;
    req_ch.priority_req <= weight;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every owed response has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mix narrow weights (many ties), the two extremes, zero and minus one, and
  // full-range weights.
  function automatic logic signed [WW-1:0] pick_weight();
    unique case ($urandom_range(3))
      0:       return WW'($urandom_range(8) - 4);
      1:       unique case ($urandom_range(3))
                 0:       return {1'b1, {(WW-1){1'b0}}};
                 1:       return {1'b0, {(WW-1){1'b1}}};
                 2:       return '0;
                 default: return '1;
               endcase
      default: return WW'($urandom);
    endcase
  endfunction

  initial begin
    int idle_plan  [4];
    int stall_plan [4];
    int join_pct;
    logic op;

    idle_plan  = '{0, 80, 0, 12};
    stall_plan = '{0, 0, 80, 12};
    join_pct   = 50;

    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= spq_pkg::MODE_JOIN;
    req_ch.item_value   <= '0;
    req_ch.priority_req <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling: leave on empty, joins at the weight extremes
    // with ties at the top, bottom and middle, fill to capacity, a join on a
    // full queue, then a few leaves to show the order.
    send_request(spq_pkg::MODE_LEAVE, 16'h0000, 16'sd0);
    send_request(spq_pkg::MODE_JOIN, 16'h0000, {1'b1, {(WW-1){1'b0}}});
    send_request(spq_pkg::MODE_JOIN, 16'hFFFF, {1'b0, {(WW-1){1'b1}}});
    send_request(spq_pkg::MODE_JOIN, 16'h1111, 16'sd0);
    send_request(spq_pkg::MODE_JOIN, 16'h2222, 16'sd0);
    send_request(spq_pkg::MODE_JOIN, 16'h3333, -16'sd1);
    send_request(spq_pkg::MODE_JOIN, 16'h4444, {1'b0, {(WW-1){1'b1}}});
    send_request(spq_pkg::MODE_JOIN, 16'h5555, {1'b1, {(WW-1){1'b0}}});
    for (int k = 0; k < CAP - 7; k++)
      send_request(spq_pkg::MODE_JOIN, VW'(16'hA000 + k), WW'((k % 3) - 1));
    send_request(spq_pkg::MODE_JOIN, 16'hBEEF, {1'b0, {(WW-1){1'b1}}});
    repeat (6) send_request(spq_pkg::MODE_LEAVE, VW'($urandom), WW'($urandom));
    wait_drained();

    // Random part, one block per idling phase. Each stretch of 40 items is
    // join-heavy or leave-heavy at random; the queue swings from full to empty.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      rsp_stall_pct = stall_plan[ph];
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (n % 40 == 0) join_pct = $urandom_range(1) ? 75 : 30;
        op = ($urandom_range(99) < join_pct) ? spq_pkg::MODE_JOIN : spq_pkg::MODE_LEAVE;
        send_request(op, VW'($urandom), pick_weight());
      end
      // pause the sender until every response is back
      wait_drained();
    end

    // Let any stray response show up before the verdict.
    rsp_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sorted_priority_queue_core.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_core.sv
tb/tb_sorted_priority_queue_core.sv
